FILE: rtl/dq_pkg.sv
// Package for the double-ended queue: depth constants, request codes and
// the control word that the top level broadcasts to the row of cells.
// No dependencies.
`default_nettype none

package dq_pkg;

  // Queue depth and the widths that follow from it.
  localparam int DQ_DEPTH = 16;
  localparam int DQ_IDX_W = (DQ_DEPTH > 1) ? $clog2(DQ_DEPTH) : 1;
  localparam int DQ_CNT_W = $clog2(DQ_DEPTH + 1);
  localparam int DQ_DATA_W = 32;

  // Request codes carried on in_op.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_SHIFT_R = 2'd1,
    CELL_SHIFT_L = 2'd2,
    CELL_LOAD    = 2'd3
  } cell_cmd_t;

  // Control word shared by all cells.
  typedef struct packed {
    cell_cmd_t             cmd;
    logic [DQ_IDX_W-1:0]   load_idx;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/dq_cell.sv
// One storage cell of the queue row: holds one word and trades it with
// its neighbors. Depends on dq_pkg.
`default_nettype none

module dq_cell
  import dq_pkg::*;
(
  input  wire logic                        clk,
  input  wire cell_ctl_t                   ctl,
  input  wire logic [DQ_IDX_W-1:0]         idx,
  input  wire logic signed [DQ_DATA_W-1:0] left_q,
  input  wire logic signed [DQ_DATA_W-1:0] right_q,
  input  wire logic signed [DQ_DATA_W-1:0] load_data,
  output logic signed [DQ_DATA_W-1:0]      data_q
);

  logic signed [DQ_DATA_W-1:0] data_r;
  logic signed [DQ_DATA_W-1:0] data_nxt;

  // Next value: take from a neighbor on a shift, or the new word on a load
  // aimed at this cell.
  always_comb begin
    data_nxt = data_r;
    case (ctl.cmd)
      CELL_SHIFT_R: data_nxt = left_q;
      CELL_SHIFT_L: data_nxt = right_q;
      CELL_LOAD: begin
        if (ctl.load_idx == idx) begin
          data_nxt = load_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Double-ended queue built as a row of shifting cells; cell 0 holds the front.
// The result strobe follows the start transfer in the next cycle.
// Throughput: one request per cycle; busy stays low, each request is at most one
// shift or load of the cell row and at most one count update.
// Reset (synchronous, rst_n low) empties the queue; the receiver cannot stall.
// Depends on dq_pkg and dq_cell.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  in_op,
  input  wire logic signed [DQ_DATA_W-1:0] in_data_in,
  output logic                             out_valid,
  output logic signed [DQ_DATA_W-1:0]      out_data_out,
  output logic                             out_underflow,
  output logic                             out_overflow,
  output logic [DQ_CNT_W-1:0]              out_occupancy
);

  logic                        accept;
  logic                        empty;
  logic                        full;
  logic [DQ_IDX_W-1:0]         last_idx;
  logic signed [DQ_DATA_W-1:0] rear_q;
  logic signed [DQ_DATA_W-1:0] cell_q [DQ_DEPTH];
  cell_ctl_t                   ctl;

  logic [DQ_CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                        valid_r, valid_nxt;
  logic signed [DQ_DATA_W-1:0] data_r, data_nxt;
  logic                        under_r, under_nxt;
  logic                        over_r, over_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == DQ_CNT_W'(DQ_DEPTH));
  assign last_idx = DQ_IDX_W'(cnt_r - DQ_CNT_W'(1));

  // Rear item: the cell just below the count, picked by an AND-OR select.
  always_comb begin
    rear_q = '0;
    for (int i = 0; i < DQ_DEPTH; i++) begin
      if (DQ_IDX_W'(i) == last_idx) begin
        rear_q = rear_q | cell_q[i];
      end
    end
  end

  // Request decode: cell row command, new count and the result fields.
  always_comb begin
    ctl.cmd      = CELL_HOLD;
    ctl.load_idx = DQ_IDX_W'(cnt_r);
    cnt_nxt      = cnt_r;
    valid_nxt    = accept;
    data_nxt     = '0;
    under_nxt    = 1'b0;
    over_nxt     = 1'b0;
    if (accept) begin
      case (in_op)
        OP_PUSH_FRONT: begin
          if (full) begin
            over_nxt = 1'b1;
          end else begin
            ctl.cmd = CELL_SHIFT_R;
            cnt_nxt = cnt_r + DQ_CNT_W'(1);
          end
        end
        OP_PUSH_REAR: begin
          if (full) begin
            over_nxt = 1'b1;
          end else begin
            ctl.cmd = CELL_LOAD;
            cnt_nxt = cnt_r + DQ_CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            under_nxt = 1'b1;
          end else begin
            data_nxt = cell_q[0];
            ctl.cmd  = CELL_SHIFT_L;
            cnt_nxt  = cnt_r - DQ_CNT_W'(1);
          end
        end
        OP_POP_REAR: begin
          if (empty) begin
            under_nxt = 1'b1;
          end else begin
            data_nxt = rear_q;
            cnt_nxt  = cnt_r - DQ_CNT_W'(1);
          end
        end
        OP_PEEK_FRONT: begin
          if (empty) begin
            under_nxt = 1'b1;
          end else begin
            data_nxt = cell_q[0];
          end
        end
        OP_PEEK_REAR: begin
          if (empty) begin
            under_nxt = 1'b1;
          end else begin
            data_nxt = rear_q;
          end
        end
        default: ctl.cmd = CELL_HOLD;
      endcase
    end
  end

  // Row of cells; the front cell takes the new word on a front push.
  for (genvar g = 0; g < DQ_DEPTH; g++) begin : g_cell
    logic signed [DQ_DATA_W-1:0] left_q;
    logic signed [DQ_DATA_W-1:0] right_q;
    if (g == 0) begin : g_first
      assign left_q = in_data_in;
    end else begin : g_mid_l
      assign left_q = cell_q[g-1];
    end
    if (g == DQ_DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[g+1];
    end
    dq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (DQ_IDX_W'(g)),
      .left_q    (left_q),
      .right_q   (right_q),
      .load_data (in_data_in),
      .data_q    (cell_q[g])
    );
  end

  // Control state and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
    data_r  <= data_nxt;
    under_r <= under_nxt;
    over_r  <= over_nxt;
  end

  assign out_valid     = valid_r;
  assign out_data_out  = data_r;
  assign out_underflow = under_r;
  assign out_overflow  = over_r;
  assign out_occupancy = cnt_r;

  // A dropped push can only be reported with the queue full.
  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_occupancy == DQ_CNT_W'(DQ_DEPTH))
    else $error("overflow reported while queue not full");

  // An underflow leaves the queue empty.
  a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_underflow |-> out_occupancy == '0)
    else $error("underflow reported while queue holds items");

  // The count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DQ_CNT_W'(DQ_DEPTH))
    else $error("item count beyond depth");

  // The count moves by at most one per request and only after a transfer.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cnt_r))
    else $error("item count changed without a transfer");

endmodule

`default_nettype wire
